// ----- hdl/cns_pkg.sv -----
package cns_pkg;

   // Field widths of the channels and the configuration port.
   localparam int SAMPLE_W    = 16;
   localparam int OUT_W       = 18;
   localparam int COEF_W      = 17;
   localparam int MODE_W      = 2;
   localparam int CSR_INDEX_W = 2;

   // The pink accumulator is four bits wider than a sample, for the largest stage count.
   localparam int PINK_SUM_W = SAMPLE_W + 4;

   // Shared multiplier operand and product widths.
   localparam int MUL_W  = 32;
   localparam int PROD_W = 64;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_NOISE_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_GAIN  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_ALPHA = 2'd2;

   // Noise mode codes. Any other code behaves as white.
   localparam logic [MODE_W-1:0] MODE_WHITE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PINK  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BROWN = 2'd2;

   // Register reset values.
   localparam logic [COEF_W-1:0] GAIN_RESET  = 17'd32768;
   localparam logic [COEF_W-1:0] ALPHA_RESET = 17'd8173;

   typedef struct packed {
      logic start;
      logic step;
   } pink_ctrl_type;

   typedef struct packed {
      logic last;
   } pink_stat_type;

endpackage

// ----- hdl/cns_req_if.sv -----
interface cns_req_if;
   import cns_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] white_sample;

   modport source (output valid, output white_sample, input ready);
   modport sink (input valid, input white_sample, output ready);

endinterface

// ----- hdl/cns_rsp_if.sv -----
interface cns_rsp_if;
   import cns_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] raw_sample;
   logic signed [OUT_W-1:0] filtered_sample;

   modport source (output valid, output raw_sample, output filtered_sample, input ready);
   modport sink (input valid, input raw_sample, input filtered_sample, output ready);

endinterface

// ----- hdl/colored_noise_shaper.sv -----
// Channel   Direction  Transfer when        Payload
// req_chan  in         valid && ready       white_sample (Q1.15)
// rsp_chan  out        valid && ready       raw_sample, filtered_sample (Q2.15)
// csr_*     in         csr_write            csr_index, csr_data
//
// An item passes S_GAIN, S_RAW, S_ALPHA and S_LOW in white mode (and mode three), after
// S_BROWN_X to S_BROWN_T in brown mode and after one S_PINK per stage and S_PINK_SUM in
// pink mode. S_LOW holds while the output register is full; req_chan.ready is high again after it.
// The time taken is set by the single shared multiplier, which every step of the gain,
// low-pass and brown divide passes through, and by the pink stage walk, one stage
// per cycle through one adder.
// Reset is synchronous and active high; it clears the pink stages, phase, brown and
// low-pass levels and loads the register reset values. No clearing pass is needed.
// A finished result waits in the output register; a new item is accepted meanwhile,
// and only its last step holds until the output register is free.
module colored_noise_shaper #(
   parameter int PINK_STAGES = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   cns_req_if.sink                              req_chan,
   cns_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write,
   input  logic [cns_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cns_pkg::COEF_W-1:0]           csr_data
);
   import cns_pkg::*;

   // Internal widths. The brown level is Q1.22, the low-pass level Q2.21.
   localparam int LEVEL_W    = 24;
   localparam int LP_W       = 24;
   localparam int LPS_W      = LP_W + 3;
   localparam int SHAPED_W   = 19;
   localparam int DIFF_W     = 25;
   localparam int RAW_FULL_W = 24;

   localparam int FRAC_SHIFT  = 16;   // Q0.16 coefficient scaling
   localparam int PINK_SHIFT  = 3;    // pink sum divided by eight
   localparam int WHITE_SHIFT = 7;    // Q1.15 sample into Q1.22
   localparam int BROWN_SHIFT = 8;    // 3.5 * level, Q1.22 down to Q.15
   localparam int LP_SHIFT    = 6;    // Q2.15 to Q2.21 and back
   localparam int DIV_SHIFT   = 36;

   // The brown update is floor((50 * level + 128 * w) / 51). The quotient is
   // estimated with a reciprocal, ceil(2^36 / 51), and corrected by one step.
   localparam logic signed [MUL_W-1:0] BROWN_KEEP  = 32'sd50;
   localparam logic signed [MUL_W-1:0] BROWN_DIV   = 32'sd51;
   localparam logic signed [MUL_W-1:0] BROWN_RECIP = 32'sd1347440721;
   localparam logic signed [MUL_W-1:0] BROWN_OUT   = 32'sd7;

   localparam logic signed [RAW_FULL_W-1:0] RAW_HI =
      {{(RAW_FULL_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
   localparam logic signed [RAW_FULL_W-1:0] RAW_LO = ~RAW_HI;
   localparam logic signed [LPS_W-1:0] LP_HI =
      {{(LPS_W - LP_W + 1){1'b0}}, {(LP_W - 1){1'b1}}};
   localparam logic signed [LPS_W-1:0] LP_LO = ~LP_HI;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PINK,
      S_PINK_SUM,
      S_BROWN_X,
      S_BROWN_Q,
      S_BROWN_R,
      S_BROWN_C,
      S_BROWN_S,
      S_BROWN_T,
      S_GAIN,
      S_RAW,
      S_ALPHA,
      S_LOW
   } state_type;

   // Configuration registers.
   logic [MODE_W-1:0] mode_ff;
   logic [COEF_W-1:0] gain_ff;
   logic [COEF_W-1:0] alpha_ff;

   // Sequencer and the state of the shaping filters.
   state_type                 state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic signed [LP_W-1:0]    lp_ff, lp_in;

   // Working registers of one item.
   logic signed [SAMPLE_W-1:0] white_ff, white_in;
   logic signed [MUL_W-1:0]    x_ff, x_in;
   logic signed [MUL_W-1:0]    q_ff, q_in;
   logic signed [SHAPED_W-1:0] shaped_ff, shaped_in;
   logic signed [OUT_W-1:0]    raw_ff, raw_in;
   logic signed [DIFF_W-1:0]   diff_ff, diff_in;
   logic signed [OUT_W-1:0]    rsp_raw_ff, rsp_raw_in;
   logic signed [OUT_W-1:0]    rsp_filt_ff, rsp_filt_in;

   // Shared multiplier and its operand selection.
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_product;

   // Pink stage bank.
   pink_ctrl_type                pink_ctrl;
   pink_stat_type                pink_stat;
   logic signed [PINK_SUM_W-1:0] pink_sum;

   // Arithmetic taken from the multiplier product.
   logic                          req_fire;
   logic                          out_free;
   logic signed [MUL_W-1:0]       q_est;
   logic signed [MUL_W-1:0]       rem;
   logic signed [RAW_FULL_W-1:0]  raw_full;
   logic signed [OUT_W-1:0]       raw_sat;
   logic signed [LPS_W-1:0]       lp_sum;
   logic signed [LP_W-1:0]        lp_new;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready           = (state_ff == S_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.raw_sample      = rsp_raw_ff;
   assign rsp_chan.filtered_sample = rsp_filt_ff;

   // Configuration writes; an index beyond the register list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_WHITE;
         gain_ff  <= GAIN_RESET;
         alpha_ff <= ALPHA_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_NOISE_MODE:   mode_ff  <= csr_data[MODE_W-1:0];
            CSR_OUTPUT_GAIN:  gain_ff  <= csr_data;
            CSR_FILTER_ALPHA: alpha_ff <= csr_data;
            default: ;
         endcase
      end
   end

   cns_mult u_mult (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_product)
   );

   assign pink_ctrl.start = req_fire && (mode_ff == MODE_PINK);
   assign pink_ctrl.step  = (state_ff == S_PINK);

   cns_pink #(
      .STAGES (PINK_STAGES)
   ) u_pink (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (pink_ctrl),
      .white_sample (white_ff),
      .stat         (pink_stat),
      .sum          (pink_sum)
   );

   // The multiplier is fed every cycle. While idle it already forms 50 * level,
   // which is the first product a brown item needs.
   always_comb begin
      unique case (state_ff)
         S_BROWN_Q: begin
            mul_a = x_ff;
            mul_b = BROWN_RECIP;
         end
         S_BROWN_R: begin
            mul_a = q_est;
            mul_b = BROWN_DIV;
         end
         S_BROWN_S: begin
            mul_a = MUL_W'(level_ff);
            mul_b = BROWN_OUT;
         end
         S_GAIN: begin
            mul_a = MUL_W'(shaped_ff);
            mul_b = MUL_W'(gain_ff);
         end
         S_ALPHA, S_LOW: begin
            // S_LOW keeps the same operands so the product holds during a stall.
            mul_a = MUL_W'(diff_ff);
            mul_b = MUL_W'(alpha_ff);
         end
         default: begin
            mul_a = MUL_W'(level_ff);
            mul_b = BROWN_KEEP;
         end
      endcase
   end

   // Quotient estimate, floor or one below floor, and the remainder check.
   assign q_est = MUL_W'(mul_product >>> DIV_SHIFT);
   assign rem   = x_ff - MUL_W'(mul_product);

   // Gain product back to Q2.15 with saturation.
   assign raw_full = RAW_FULL_W'(mul_product >>> FRAC_SHIFT);
   always_comb begin
      if (raw_full > RAW_HI) begin
         raw_sat = OUT_W'(RAW_HI);
      end else if (raw_full < RAW_LO) begin
         raw_sat = OUT_W'(RAW_LO);
      end else begin
         raw_sat = OUT_W'(raw_full);
      end
   end

   // Low-pass step with saturation of the level.
   assign lp_sum = LPS_W'(lp_ff) + LPS_W'(mul_product >>> FRAC_SHIFT);
   always_comb begin
      if (lp_sum > LP_HI) begin
         lp_new = LP_W'(LP_HI);
      end else if (lp_sum < LP_LO) begin
         lp_new = LP_W'(LP_LO);
      end else begin
         lp_new = LP_W'(lp_sum);
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      level_in     = level_ff;
      lp_in        = lp_ff;
      white_in     = white_ff;
      x_in         = x_ff;
      q_in         = q_ff;
      shaped_in    = shaped_ff;
      raw_in       = raw_ff;
      diff_in      = diff_ff;
      rsp_raw_in   = rsp_raw_ff;
      rsp_filt_in  = rsp_filt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               white_in = req_chan.white_sample;
               unique case (mode_ff)
                  MODE_PINK:  state_in = S_PINK;
                  MODE_BROWN: state_in = S_BROWN_X;
                  default: begin
                     shaped_in = SHAPED_W'(req_chan.white_sample);
                     state_in  = S_GAIN;
                  end
               endcase
            end
         end
         S_PINK: begin
            // The stage bank walks one stage per cycle.
            if (pink_stat.last) begin
               state_in = S_PINK_SUM;
            end
         end
         S_PINK_SUM: begin
            shaped_in = SHAPED_W'(pink_sum >>> PINK_SHIFT);
            state_in  = S_GAIN;
         end
         S_BROWN_X: begin
            x_in     = MUL_W'(mul_product) + (MUL_W'(white_ff) <<< WHITE_SHIFT);
            state_in = S_BROWN_Q;
         end
         S_BROWN_Q: begin
            state_in = S_BROWN_R;
         end
         S_BROWN_R: begin
            q_in     = q_est;
            state_in = S_BROWN_C;
         end
         S_BROWN_C: begin
            // The estimate is low by one when the remainder reaches the divisor.
            if (rem >= BROWN_DIV) begin
               level_in = LEVEL_W'(q_ff + MUL_W'(1));
            end else begin
               level_in = LEVEL_W'(q_ff);
            end
            state_in = S_BROWN_S;
         end
         S_BROWN_S: begin
            state_in = S_BROWN_T;
         end
         S_BROWN_T: begin
            shaped_in = SHAPED_W'(mul_product >>> BROWN_SHIFT);
            state_in  = S_GAIN;
         end
         S_GAIN: begin
            state_in = S_RAW;
         end
         S_RAW: begin
            raw_in   = raw_sat;
            diff_in  = (DIFF_W'(raw_sat) <<< LP_SHIFT) - DIFF_W'(lp_ff);
            state_in = S_ALPHA;
         end
         S_ALPHA: begin
            state_in = S_LOW;
         end
         S_LOW: begin
            // The filter state and the result move together, once the output
            // register has room.
            if (out_free) begin
               lp_in        = lp_new;
               rsp_valid_in = 1'b1;
               rsp_raw_in   = raw_ff;
               rsp_filt_in  = OUT_W'(lp_new >>> LP_SHIFT);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         level_ff     <= '0;
         lp_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         lp_ff        <= lp_in;
      end
   end

   always_ff @(posedge clock) begin
      white_ff    <= white_in;
      x_ff        <= x_in;
      q_ff        <= q_in;
      shaped_ff   <= shaped_in;
      raw_ff      <= raw_in;
      diff_ff     <= diff_in;
      rsp_raw_ff  <= rsp_raw_in;
      rsp_filt_ff <= rsp_filt_in;
   end

endmodule

// ----- hdl/cns_mult.sv -----
module cns_mult (
   input  logic                               clock,
   input  logic signed [cns_pkg::MUL_W-1:0]   op_a,
   input  logic signed [cns_pkg::MUL_W-1:0]   op_b,
   output logic signed [cns_pkg::PROD_W-1:0]  product
);
   import cns_pkg::*;

   logic signed [PROD_W-1:0] product_ff;
   logic signed [PROD_W-1:0] product_in;

   // Full signed product; operands are sign-extended to the product width.
   assign product_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ----- hdl/cns_pink.sv -----
module cns_pink #(
   parameter int STAGES = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cns_pkg::pink_ctrl_type                ctrl,
   input  logic signed [cns_pkg::SAMPLE_W-1:0]   white_sample,
   output cns_pkg::pink_stat_type                stat,
   output logic signed [cns_pkg::PINK_SUM_W-1:0] sum
);
   import cns_pkg::*;

   localparam int IDX_W = (STAGES > 1) ? $clog2(STAGES) : 1;

   logic [STAGES-1:0]            phase_ff, phase_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic signed [PINK_SUM_W-1:0] sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0]   stage_ff [STAGES];
   logic                         reload;
   logic signed [SAMPLE_W-1:0]   term;

   // A stage takes the new sample when its phase bit is clear.
   assign reload = !phase_ff[idx_ff];
   assign term   = reload ? white_sample : stage_ff[idx_ff];

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      if (ctrl.start) begin
         phase_in = phase_ff + STAGES'(1);
         idx_in   = '0;
         sum_in   = '0;
      end else if (ctrl.step) begin
         idx_in = idx_ff + IDX_W'(1);
         sum_in = sum_ff + PINK_SUM_W'(term);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         idx_ff   <= '0;
         sum_ff   <= '0;
         for (int i = 0; i < STAGES; i++) begin
            stage_ff[i] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         sum_ff   <= sum_in;
         if (ctrl.step && reload) begin
            stage_ff[idx_ff] <= white_sample;
         end
      end
   end

   assign stat.last = (idx_ff == IDX_W'(STAGES - 1));
   assign sum       = sum_ff;

endmodule

// ----- hdl/cns_checker.sv -----
module cns_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [cns_pkg::OUT_W-1:0]        rsp_raw_sample,
   input logic [cns_pkg::OUT_W-1:0]        rsp_filtered_sample
);
   import cns_pkg::*;

   // A stalled result keeps its value until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_raw_sample)
                                  && $stable(rsp_filtered_sample))
      else $error("result changed or dropped while stalled");

   // Even the shortest item keeps the input side closed through its gain, raw, alpha and low-pass steps.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("input reopened before the item was finished");

   // A new result only comes out of the last step of an item in progress.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while the block was idle");

   // Back-to-back results are impossible without an item in progress in between.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid || !$past(req_ready))
      else $error("result repeated without a new item");

endmodule

bind colored_noise_shaper cns_checker u_cns_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_raw_sample      (rsp_chan.raw_sample),
   .rsp_filtered_sample (rsp_chan.filtered_sample)
);
